### rtl/core/sbld_pkg.sv
// Shared types, constants and helper functions of the stereo biquad lowpass with dither.
package sbld_pkg;

  // Fixed datapath widths
  localparam int ST_W   = 56;  // filter state and product saturation width
  localparam int WIDE_W = 64;  // working width of sums before saturation
  localparam int COEF_W = 32;  // coefficient width
  localparam int SEED_W = 32;  // noise generator width
  localparam int SH_W   = 5;   // dither shift width

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A0      = 3'd0,
    REG_COEF_B1      = 3'd1,
    REG_COEF_B2      = 3'd2,
    REG_DITHER_EN    = 3'd3,
    REG_DITHER_SHIFT = 3'd4
  } cfg_reg_e;

  // Register reset values
  localparam logic signed [COEF_W-1:0] A0_RST    = 32'sd241484536;
  localparam logic signed [COEF_W-1:0] B1_RST    = 32'sd480257875;
  localparam logic signed [COEF_W-1:0] B2_RST    = 32'sd217244815;
  localparam logic [SH_W-1:0]          SHIFT_RST = 5'd24;

  // Generator seeds and noise offset
  localparam logic [SEED_W-1:0]        SEED_LEFT  = 32'h2545_F491;
  localparam logic [SEED_W-1:0]        SEED_RIGHT = 32'h9E37_79B9;
  localparam logic signed [SEED_W:0]   NOISE_OFS  = 33'sh0_7FFF_FFFF;

  // Saturation bounds of the state width, held at the working width
  localparam logic signed [WIDE_W-1:0] ST_MAX = 64'sh007F_FFFF_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] ST_MIN = 64'shFF80_0000_0000_0000;

  // Channel select
  localparam logic CH_L = 1'b0;
  localparam logic CH_R = 1'b1;

  // Microprogram
  localparam int PROG_LEN = 22;
  localparam int PC_W     = $clog2(PROG_LEN);
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_XA,
    OP_SAT_PA,
    OP_ADD_T,
    OP_ROUND_Y,
    OP_MUL_YB1,
    OP_S1_PRE,
    OP_S1_FIN,
    OP_MUL_YB2,
    OP_S2_FIN,
    OP_DITHER,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    W_NONE,
    W_IN,
    W_OUT
  } wait_e;

  // One control word of the program
  typedef struct packed {
    op_e   op;
    logic  ch;
    logic  seed_en;
    wait_e wt;
    logic  jump;
    pc_t   target;
  } ucode_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic fire;
    op_e  op;
    logic ch;
    logic seed_en;
  } ctl_t;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic                     dith_en;
    logic [SH_W-1:0]          dith_sh;
  } cfg_t;

  // Clamp a working-width value to the state width
  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [WIDE_W-1:0] v);
    logic signed [ST_W-1:0] r;
    if (v > ST_MAX) begin
      r = ST_MAX[ST_W-1:0];
    end else if (v < ST_MIN) begin
      r = ST_MIN[ST_W-1:0];
    end else begin
      r = v[ST_W-1:0];
    end
    return r;
  endfunction

  // xorshift32 with shifts 13, 17, 5
  function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

### rtl/core/sbld_seq.sv
// Microcode sequencer: step counter, program ROM and wait/jump control.
module sbld_seq import sbld_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_busy_i,
  output logic in_ready_o,
  output ctl_t ctl_o
);

  pc_t    pc_q, pc_d;
  ucode_t word;
  logic   hold;

  function automatic ucode_t mk(input op_e op, input logic ch, input logic seed_en,
                                input wait_e wt, input logic jump, input pc_t target);
    ucode_t u;
    u.op      = op;
    u.ch      = ch;
    u.seed_en = seed_en;
    u.wt      = wt;
    u.jump    = jump;
    u.target  = target;
    return u;
  endfunction

  // Program ROM: load, left channel, right channel, emit
  function automatic ucode_t rom(input pc_t pc);
    ucode_t u;
    unique case (pc)
      PC_W'(0):  u = mk(OP_LOAD,    CH_L, 1'b0, W_IN,   1'b0, '0);
      PC_W'(1):  u = mk(OP_MUL_XA,  CH_L, 1'b1, W_NONE, 1'b0, '0);
      PC_W'(2):  u = mk(OP_SAT_PA,  CH_L, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(3):  u = mk(OP_ADD_T,   CH_L, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(4):  u = mk(OP_ROUND_Y, CH_L, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(5):  u = mk(OP_MUL_YB1, CH_L, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(6):  u = mk(OP_S1_PRE,  CH_L, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(7):  u = mk(OP_S1_FIN,  CH_L, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(8):  u = mk(OP_MUL_YB2, CH_L, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(9):  u = mk(OP_S2_FIN,  CH_L, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(10): u = mk(OP_DITHER,  CH_L, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(11): u = mk(OP_MUL_XA,  CH_R, 1'b1, W_NONE, 1'b0, '0);
      PC_W'(12): u = mk(OP_SAT_PA,  CH_R, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(13): u = mk(OP_ADD_T,   CH_R, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(14): u = mk(OP_ROUND_Y, CH_R, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(15): u = mk(OP_MUL_YB1, CH_R, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(16): u = mk(OP_S1_PRE,  CH_R, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(17): u = mk(OP_S1_FIN,  CH_R, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(18): u = mk(OP_MUL_YB2, CH_R, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(19): u = mk(OP_S2_FIN,  CH_R, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(20): u = mk(OP_DITHER,  CH_R, 1'b0, W_NONE, 1'b0, '0);
      PC_W'(21): u = mk(OP_EMIT,    CH_L, 1'b0, W_OUT,  1'b1, '0);
      default:   u = mk(OP_NOP,     CH_L, 1'b0, W_NONE, 1'b1, '0);
    endcase
    return u;
  endfunction

  assign word = rom(pc_q);

  // Hold the step while its wait condition is open
  always_comb begin
    hold = ((word.wt == W_IN) && !in_valid_i) || ((word.wt == W_OUT) && out_busy_i);
  end

  // Next step
  always_comb begin
    if (hold) begin
      pc_d = pc_q;
    end else if (word.jump) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  // Control outputs
  always_comb begin
    ctl_o.fire    = !hold;
    ctl_o.op      = word.op;
    ctl_o.ch      = word.ch;
    ctl_o.seed_en = word.seed_en;
    in_ready_o    = (word.wt == W_IN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef SYNTH
  // Step counter stays inside the program
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < PC_W'(PROG_LEN))
    else $error("step counter outside program");

  // A transfer in moves the program off the load step
  a_leave_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && in_valid_i) |=> !in_ready_o)
    else $error("load step repeated after transfer");
`endif

endmodule

### rtl/core/sbld_dp.sv
// Datapath: shared multiplier, accumulator, filter state, noise generators and output register.
module sbld_dp import sbld_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctl_t                          ctl_i,
  input  cfg_t                          cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic                          out_busy_o,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o
);

  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam logic signed [WIDE_W-1:0] SMP_MAX =
    signed'((WIDE_W'(1) << (SAMPLE_BITS - 1)) - WIDE_W'(1));
  localparam logic signed [WIDE_W-1:0] SMP_MIN  = -SMP_MAX - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] RND_HALF =
    signed'(WIDE_W'(1) << (COEF_FRAC_BITS - 1));

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [WIDE_W-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SMP_MAX) begin
      r = SMP_MAX[SAMPLE_BITS-1:0];
    end else if (v < SMP_MIN) begin
      r = SMP_MIN[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  // Payload registers
  logic signed [SAMPLE_BITS-1:0] x_q [2];
  logic signed [SAMPLE_BITS-1:0] res_q [2];
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [WIDE_W-1:0]      acc_q;
  logic signed [ST_W-1:0]        pa_q;
  logic signed [SAMPLE_BITS-1:0] y_q;
  logic signed [SAMPLE_BITS-1:0] left_out_q, right_out_q;

  // Control and filter state
  logic signed [ST_W-1:0] s1_q [2];
  logic signed [ST_W-1:0] s2_q [2];
  logic [SEED_W-1:0]      seed_q [2];
  logic                   out_valid_q, out_valid_d;

  // Combinational datapath
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [COEF_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]      prod_d;
  logic signed [ST_W-1:0]        prod_sat, pa_dbl, t_sat;
  logic signed [WIDE_W-1:0]      rnd;
  logic signed [SAMPLE_BITS-1:0] y_new, dith_y;
  logic signed [SEED_W:0]        noise, noise_sh;
  logic                          do_emit;

  // Shared multiplier operands
  always_comb begin
    mul_a = (ctl_i.op == OP_MUL_XA) ? x_q[ctl_i.ch] : y_q;
    unique case (ctl_i.op)
      OP_MUL_XA:  mul_b = cfg_i.a0;
      OP_MUL_YB1: mul_b = cfg_i.b1;
      default:    mul_b = cfg_i.b2;
    endcase
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Saturation, rounding and dither
  always_comb begin
    prod_sat = sat_st(WIDE_W'(prod_q));
    pa_dbl   = sat_st(WIDE_W'(pa_q) <<< 1);
    t_sat    = sat_st(acc_q);
    rnd      = (WIDE_W'(t_sat) + RND_HALF) >>> COEF_FRAC_BITS;
    y_new    = sat_smp(rnd);
    noise    = signed'({1'b0, seed_q[ctl_i.ch]}) - NOISE_OFS;
    noise_sh = noise >>> cfg_i.dith_sh;
    dith_y   = cfg_i.dith_en ? sat_smp(WIDE_W'(y_q) + WIDE_W'(noise_sh)) : y_q;
  end

  // Output register handshake
  always_comb begin
    do_emit = ctl_i.fire && (ctl_i.op == OP_EMIT);
    if (do_emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // State updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      s1_q[0]     <= '0;
      s1_q[1]     <= '0;
      s2_q[0]     <= '0;
      s2_q[1]     <= '0;
      seed_q[0]   <= SEED_LEFT;
      seed_q[1]   <= SEED_RIGHT;
    end else begin
      out_valid_q <= out_valid_d;
      if (ctl_i.fire && ctl_i.seed_en) begin
        seed_q[ctl_i.ch] <= xorshift(seed_q[ctl_i.ch]);
      end
      if (ctl_i.fire && (ctl_i.op == OP_S1_FIN)) begin
        s1_q[ctl_i.ch] <= sat_st(acc_q - WIDE_W'(prod_sat));
      end
      if (ctl_i.fire && (ctl_i.op == OP_S2_FIN)) begin
        s2_q[ctl_i.ch] <= sat_st(WIDE_W'(pa_q) - WIDE_W'(prod_sat));
      end
    end
  end

  // Payload updates, one operation per step
  always_ff @(posedge clk_i) begin
    if (ctl_i.fire) begin
      unique case (ctl_i.op)
        OP_LOAD: begin
          x_q[0] <= left_sample_i;
          x_q[1] <= right_sample_i;
        end
        OP_MUL_XA, OP_MUL_YB1, OP_MUL_YB2: prod_q <= prod_d;
        OP_SAT_PA:  pa_q <= prod_sat;
        OP_ADD_T:   acc_q <= WIDE_W'(pa_q) + WIDE_W'(s1_q[ctl_i.ch]);
        OP_ROUND_Y: y_q <= y_new;
        OP_S1_PRE:  acc_q <= WIDE_W'(pa_dbl) + WIDE_W'(s2_q[ctl_i.ch]);
        OP_DITHER:  res_q[ctl_i.ch] <= dith_y;
        OP_EMIT: begin
          left_out_q  <= res_q[0];
          right_out_q <= res_q[1];
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_busy_o  = out_valid_q && out_stall_i;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

`ifndef SYNTH
  // The emit step never overwrites a result still held by the receiver
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_emit && out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // An emit always presents a result on the next cycle
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_emit |=> out_valid_q)
    else $error("emit without output valid");
`endif

endmodule

### rtl/core/stereo_biquad_lowpass_dither_unit.sv
// Top level: configuration registers, microcode sequencer and datapath of the stereo lowpass.
//
// Stereo second-order lowpass (transposed direct form II) with optional dither.
// Input channel: in_valid_i / in_stall_o with left_sample_i and right_sample_i;
// a transfer happens on a rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with left_out_o and right_out_o.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (a0, b1, b2,
// dither enable, dither shift); other indexes are ignored. Write only while idle.
// The program runs one operation per step through a single shared multiplier,
// ten steps per channel plus load and emit; the result is registered at the emit
// step, and a new input is taken only once the program returns to its load step.
// The next input is taken while a finished result waits in the output register.
// While the receiver stalls, the result holds; the following item computes and
// then waits at the emit step until the output register frees up.
// Reset clears the filter state, loads the generator seeds and the register
// reset values; the block is ready for input on the first cycle after reset.
module stereo_biquad_lowpass_dither_unit import sbld_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i
);

  cfg_t cfg_q;
  ctl_t ctl;
  logic in_ready;
  logic out_busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a0      <= A0_RST;
      cfg_q.b1      <= B1_RST;
      cfg_q.b2      <= B2_RST;
      cfg_q.dith_en <= 1'b0;
      cfg_q.dith_sh <= SHIFT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COEF_A0:      cfg_q.a0      <= signed'(cfg_wdata_i[COEF_W-1:0]);
        REG_COEF_B1:      cfg_q.b1      <= signed'(cfg_wdata_i[COEF_W-1:0]);
        REG_COEF_B2:      cfg_q.b2      <= signed'(cfg_wdata_i[COEF_W-1:0]);
        REG_DITHER_EN:    cfg_q.dith_en <= cfg_wdata_i[0];
        REG_DITHER_SHIFT: cfg_q.dith_sh <= cfg_wdata_i[SH_W-1:0];
        default: ;
      endcase
    end
  end

  sbld_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_busy),
    .in_ready_o (in_ready),
    .ctl_o      (ctl)
  );

  sbld_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .cfg_i          (cfg_q),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_busy_o     (out_busy),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o)
  );

  assign in_stall_o = !in_ready;

endmodule
